/* rtl/core/rbei_pkg.sv */
// Shared constants, types and state encoding for the random bit error injector.
`timescale 1ns / 1ps

package rbei_pkg;

  localparam int WORD_WIDTH      = 32;
  localparam int GAP_WIDTH_DEF   = 32;
  localparam int BYTE_BITS       = 8;
  localparam int CFG_IDX_W       = 1;

  localparam logic [WORD_WIDTH-1:0] LFSR_TAPS     = 32'h8020_0003;
  localparam logic [WORD_WIDTH-1:0] GAP_RANGE_RST = 32'd1023;
  localparam logic [WORD_WIDTH-1:0] SEED_RST      = 32'd1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAP_RANGE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RNG_SEED  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_CHECK,
    ST_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;       // latch input byte, clear mask
    logic draw_start;   // step LFSR, start remainder unit
    logic apply;        // fold finished gap into distance
    logic mark;         // set mask bit at current distance
    logic finish_dist;  // distance minus one byte
    logic load_out;     // move result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic armed;
    logic div_done;
    logic dist_lt8;
    logic out_free;
  } status_t;

endpackage

/* rtl/core/random_bit_error_injector_core.sv */
// Top level of the random bit error injector.
//
// channel  dir  handshake                      payload
// s_axis   in   s_axis_tvalid / s_axis_tready  tdata[7:0] data_byte
// m_axis   out  m_axis_tvalid / m_axis_tready  tdata[7:0] flipped_byte, [15:8] error_mask
// cfg      in   cfg_we_i                       cfg_idx_i, cfg_data_i
//
// Each flipped bit of a byte costs one draw of the next distance; the first byte
// after reset or a range change also draws its first distance.
// Each draw is set by the bit-serial remainder unit: 32 iterations plus hand-off.
// Reset loads gap_range 1023 and seed 1; the first distance is drawn on the next byte.
// A finished result waits in the output register; the next byte is taken meanwhile,
// and stalls before its hand-off while that register is still full.
`timescale 1ns / 1ps

module random_bit_error_injector_core #(
  parameter int GAP_WIDTH = rbei_pkg::GAP_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rbei_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rbei_pkg::WORD_WIDTH-1:0] cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata   // [7:0] flipped_byte, [15:8] error_mask
);

  rbei_pkg::cmd_t    cmd;
  rbei_pkg::status_t status;
  logic [7:0]        flipped_byte;
  logic [7:0]        error_mask;

  rbei_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rbei_datapath #(
    .GAP_WIDTH (GAP_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .data_byte_i    (s_axis_tdata),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .flipped_byte_o (flipped_byte),
    .error_mask_o   (error_mask),
    .cmd_i          (cmd),
    .status_o       (status)
  );

  assign m_axis_tdata = {error_mask, flipped_byte};

endmodule

/* rtl/core/rbei_divmod.sv */
// Bit-serial restoring remainder unit: one quotient bit per cycle.
`timescale 1ns / 1ps

module rbei_divmod (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [rbei_pkg::WORD_WIDTH-1:0] dividend_i,
  input  logic [rbei_pkg::WORD_WIDTH-1:0] divisor_i,
  output logic                           done_o,
  output logic [rbei_pkg::WORD_WIDTH-1:0] rem_o
);

  localparam int W  = rbei_pkg::WORD_WIDTH;
  localparam int CW = $clog2(W + 1);

  logic          active_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  shift_q;
  logic [W-1:0]  div_q;
  logic [W:0]    trial;
  logic [W:0]    diff;

  always_comb begin
    trial = {rem_q, shift_q[W-1]};
    diff  = trial - {1'b0, div_q};
    // no borrow means trial >= divisor, so the difference fits in W bits
    rem_d = diff[W] ? trial[W-1:0] : diff[W-1:0];
  end

  assign done_o = active_q && (cnt_q == '0);
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
    end else if (start_i) begin
      active_q <= 1'b1;
      cnt_q    <= CW'(W);
    end else if (active_q) begin
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - CW'(1);
      end else begin
        active_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q   <= '0;
      shift_q <= dividend_i;
      div_q   <= divisor_i;
    end else if (active_q && (cnt_q != '0)) begin
      rem_q   <= rem_d;
      shift_q <= {shift_q[W-2:0], 1'b0};
    end
  end

endmodule

/* rtl/core/rbei_datapath.sv */
// Datapath: configuration, LFSR, bit distance, error mask and output register.
`timescale 1ns / 1ps

module rbei_datapath #(
  parameter int GAP_WIDTH = rbei_pkg::GAP_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rbei_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rbei_pkg::WORD_WIDTH-1:0] cfg_data_i,
  input  logic [7:0]                      data_byte_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [7:0]                      flipped_byte_o,
  output logic [7:0]                      error_mask_o,
  input  rbei_pkg::cmd_t                  cmd_i,
  output rbei_pkg::status_t               status_o
);

  localparam int W  = rbei_pkg::WORD_WIDTH;
  localparam int DW = GAP_WIDTH + 1;

  logic [W-1:0]         gap_range_q;
  logic [W-1:0]         word_q;
  logic [W-1:0]         word_next;
  logic                 armed_q;
  logic [DW-1:0]        dist_q;
  logic [7:0]           data_q;
  logic [7:0]           mask_q;
  logic                 out_valid_q;
  logic [7:0]           out_corr_q;
  logic [7:0]           out_mask_q;
  logic                 div_done;
  logic [W-1:0]         div_rem;
  logic [GAP_WIDTH-1:0] gap;
  logic                 out_free;
  logic                 dist_lt8;

  assign word_next = {1'b0, word_q[W-1:1]} ^ (word_q[0] ? rbei_pkg::LFSR_TAPS : '0);

  rbei_divmod u_divmod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.draw_start),
    .dividend_i (word_next),
    .divisor_i  (gap_range_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // zero range gives a zero gap
  assign gap      = (gap_range_q == '0) ? '0 : GAP_WIDTH'(div_rem);
  assign dist_lt8 = dist_q < DW'(rbei_pkg::BYTE_BITS);
  assign out_free = !out_valid_q || out_ready_i;

  assign status_o.armed    = armed_q;
  assign status_o.div_done = div_done;
  assign status_o.dist_lt8 = dist_lt8;
  assign status_o.out_free = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_range_q <= rbei_pkg::GAP_RANGE_RST;
      word_q      <= rbei_pkg::SEED_RST;
      armed_q     <= 1'b0;
      dist_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == rbei_pkg::REG_GAP_RANGE)) begin
        if (cfg_data_i != gap_range_q) begin
          gap_range_q <= cfg_data_i;
          armed_q     <= 1'b0;
        end
      end else if (cfg_we_i && (cfg_idx_i == rbei_pkg::REG_RNG_SEED)) begin
        word_q <= (cfg_data_i == '0) ? rbei_pkg::SEED_RST : cfg_data_i;
      end else begin
        if (cmd_i.draw_start) begin
          word_q <= word_next;
        end
        if (cmd_i.apply) begin
          armed_q <= 1'b1;
          // first draw sets the distance, later ones advance past the flip
          dist_q  <= armed_q ? dist_q + DW'(1) + DW'(gap) : DW'(gap);
        end else if (cmd_i.finish_dist) begin
          dist_q <= dist_q - DW'(rbei_pkg::BYTE_BITS);
        end
      end

      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      data_q <= data_byte_i;
      mask_q <= '0;
    end else if (cmd_i.mark) begin
      mask_q[dist_q[2:0]] <= 1'b1;
    end
    if (cmd_i.load_out) begin
      out_corr_q <= data_q ^ mask_q;
      out_mask_q <= mask_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign flipped_byte_o = out_corr_q;
  assign error_mask_o   = out_mask_q;

  a_apply_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.apply |-> div_done)
    else $error("gap applied before remainder finished");

  a_mark_in_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mark |-> dist_lt8)
    else $error("mask bit set with distance outside the byte");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> out_free)
    else $error("output register overwritten while full");

  a_dist_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish_dist |=> !dist_q[GAP_WIDTH])
    else $error("carried distance exceeds gap width");

endmodule

/* rtl/core/rbei_ctrl.sv */
// Controller: sequences draws, flips and result hand-off for one byte.
`timescale 1ns / 1ps

module rbei_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rbei_pkg::status_t status_i,
  output rbei_pkg::cmd_t    cmd_o
);

  rbei_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      rbei_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.armed ? rbei_pkg::ST_CHECK : rbei_pkg::ST_WAIT;
        end
      end
      rbei_pkg::ST_WAIT: begin
        if (status_i.div_done) state_d = rbei_pkg::ST_CHECK;
      end
      rbei_pkg::ST_CHECK: begin
        state_d = status_i.dist_lt8 ? rbei_pkg::ST_WAIT : rbei_pkg::ST_DONE;
      end
      rbei_pkg::ST_DONE: begin
        if (status_i.out_free) state_d = rbei_pkg::ST_IDLE;
      end
      default: state_d = rbei_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      rbei_pkg::ST_IDLE: begin
        in_ready_o        = 1'b1;
        cmd_o.accept      = in_valid_i;
        cmd_o.draw_start  = in_valid_i && !status_i.armed;
      end
      rbei_pkg::ST_WAIT: begin
        cmd_o.apply = status_i.div_done;
      end
      rbei_pkg::ST_CHECK: begin
        cmd_o.mark        = status_i.dist_lt8;
        cmd_o.draw_start  = status_i.dist_lt8;
        cmd_o.finish_dist = !status_i.dist_lt8;
      end
      rbei_pkg::ST_DONE: begin
        cmd_o.load_out = status_i.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rbei_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sim/testbench.sv */
// Testbench for the random bit error injector core: directed and random traffic vs. predictor.
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_CYCLES  = 3_000_000;
  localparam int HOLD_CYCLES = 600;
  localparam int IDLE_PCT    = 32;
  localparam int MAX_SHOWN   = 10;

  typedef struct packed {
    logic [7:0] corrupted;
    logic [7:0] flips;
  } byte_result_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [rbei_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [rbei_pkg::WORD_WIDTH-1:0] cfg_data_i;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [7:0]                      s_axis_tdata;   // [7:0] data_byte
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [15:0]                     m_axis_tdata;   // [7:0] flipped_byte, [15:8] error_mask

  // predictor state
  logic [31:0] gap_range_q;
  logic [31:0] lfsr_q;
  logic [32:0] distance_q;
  logic        armed_q;

  byte_result_t pending_results[$];
  int           fail_count = 0;
  int           cycle_count = 0;
  logic         calm = 1'b0;
  int           hold_reqs = 0;
  int           hold_seen = 0;
  int           hold_left = 0;

  random_bit_error_injector_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // one Galois step, then the new word modulo the range
  function automatic logic [31:0] next_gap();
    logic lsb;
    lsb = lfsr_q[0];
    lfsr_q = lfsr_q >> 1;
    if (lsb) lfsr_q = lfsr_q ^ rbei_pkg::LFSR_TAPS;
    if (gap_range_q == 32'd0) return 32'd0;
    return lfsr_q % gap_range_q;
  endfunction

  function automatic byte_result_t inject_errors(input logic [7:0] data);
    logic [63:0]  d;
    byte_result_t res;
    res.flips = '0;
    if (!armed_q) begin
      distance_q = {1'b0, next_gap()};
      armed_q = 1'b1;
    end
    d = 64'(distance_q);
    while (d < 64'd8) begin
      res.flips[d[2:0]] = 1'b1;
      d = d + 64'd1 + 64'(next_gap());
    end
    distance_q = 33'(d - 64'd8);
    res.corrupted = data ^ res.flips;
    return res;
  endfunction

  task automatic flag_error(input string msg);
    if (fail_count < MAX_SHOWN) $display("%0t: %s", $time, msg);
    fail_count++;
  endtask

  // receiver: random idling, calm stretches, and one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    byte_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("result with nothing expected: tdata %h", m_axis_tdata));
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[7:0] !== want.corrupted)
          flag_error($sformatf("flipped_byte exp %h got %h", want.corrupted,
                               m_axis_tdata[7:0]));
        if (m_axis_tdata[15:8] !== want.flips)
          flag_error($sformatf("error_mask exp %h got %h", want.flips, m_axis_tdata[15:8]));
      end
    end
  end

  task automatic send_byte(input logic [7:0] data);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(inject_errors(data));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [rbei_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == rbei_pkg::REG_GAP_RANGE) begin
      if (value != gap_range_q) begin
        gap_range_q = value;
        armed_q = 1'b0;
      end
    end else if (idx == rbei_pkg::REG_RNG_SEED) begin
      lfsr_q = (value == 32'd0) ? 32'd1 : value;
    end
  endtask

  task automatic test_reset_values();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    send_byte(8'h5A);
    wait_drained();
  endtask

  // zero range: every bit of every byte flips
  task automatic test_zero_range();
    write_cfg(rbei_pkg::REG_GAP_RANGE, 32'd0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h3C);
    wait_drained();
  endtask

  // rewriting the same range must not redraw the distance
  task automatic test_same_range_rewrite();
    write_cfg(rbei_pkg::REG_GAP_RANGE, 32'd3);
    send_byte(8'h81);
    send_byte(8'h7E);
    wait_drained();
    write_cfg(rbei_pkg::REG_GAP_RANGE, 32'd3);
    send_byte(8'h0F);
    send_byte(8'hF0);
    wait_drained();
  endtask

  // zero seed loads one; a seed write keeps the current distance
  task automatic test_seed_reload();
    write_cfg(rbei_pkg::REG_RNG_SEED, 32'd0);
    send_byte(8'h55);
    send_byte(8'hAA);
    wait_drained();
    write_cfg(rbei_pkg::REG_RNG_SEED, 32'hFFFF_FFFF);
    send_byte(8'h01);
    send_byte(8'h80);
    wait_drained();
  endtask

  task automatic test_range_extremes();
    write_cfg(rbei_pkg::REG_GAP_RANGE, 32'd1);
    send_byte(8'hC3);
    send_byte(8'h3C);
    wait_drained();
    write_cfg(rbei_pkg::REG_GAP_RANGE, 32'hFFFF_FFFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h99);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    logic [31:0] range_val;
    int          count;
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0:       begin range_val = 32'd0;                        count = 40;  end
        1:       begin range_val = 32'd1;                        count = 40;  end
        2:       begin range_val = 32'd2;                        count = 80;  end
        3:       begin range_val = $urandom_range(8, 3);         count = 120; end
        4:       begin range_val = $urandom_range(64, 9);        count = 200; end
        5:       begin range_val = $urandom_range(1022, 65);     count = 300; end
        6:       begin range_val = rbei_pkg::GAP_RANGE_RST;      count = 300; end
        7:       begin range_val = $urandom_range(1 << 20, 1024); count = 300; end
        8:       begin range_val = 32'hFFFF_FFFF;                count = 100; end
        9:       begin range_val = $urandom();                   count = 100; end
        10:      begin range_val = $urandom_range(32, 2);        count = 200; end
        default: begin range_val = $urandom_range(2000, 100);    count = 250; end
      endcase
      wait_drained();
      write_cfg(rbei_pkg::REG_GAP_RANGE, range_val);
      if (ph % 2 == 0)
        write_cfg(rbei_pkg::REG_RNG_SEED, ($urandom_range(3) == 0) ? 32'd0 : $urandom());
      calm <= (ph == 5);
      // stall the output long enough that the input backs up
      if (ph == 6) hold_reqs <= hold_reqs + 1;
      repeat (count) send_byte(8'($urandom_range(255)));
    end
    wait_drained();
    calm <= 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = rbei_pkg::REG_GAP_RANGE;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    gap_range_q   = rbei_pkg::GAP_RANGE_RST;
    lfsr_q        = rbei_pkg::SEED_RST;
    distance_q    = '0;
    armed_q       = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_zero_range();
    test_same_range_rewrite();
    test_seed_reload();
    test_range_extremes();
    test_random_traffic();

    // longest byte needs nine draws
    repeat (320) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/rbei_pkg.sv
rtl/core/rbei_divmod.sv
rtl/core/rbei_datapath.sv
rtl/core/rbei_ctrl.sv
rtl/core/random_bit_error_injector_core.sv
sim/testbench.sv
